@@ rtl/core/rgbh_pkg.sv @@
// Shared types and constants for the RGB histogram block.
package rgbh_pkg;

    // Request kinds carried in s_tuser
    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Channel codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_NONE  = 2'd3;
    localparam int         CH_COUNT = 3;

    // Fixed field widths
    localparam int COMP_W    = 8;
    localparam int HEIGHT_W  = 12;
    localparam int OUT_CNT_W = 24;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 64;

    localparam logic [HEIGHT_W-1:0] PLOT_HEIGHT_RST = 12'd400;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_G,
        ST_PIX_B,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_RD_START,
        ST_RD_DIV
    } hist_state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ rtl/core/rgbh_div.sv @@
// Restoring divider that yields a HEIGHT_W-bit quotient, one bit per cycle.
module rgbh_div #(
    parameter int DEN_W = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [DEN_W+rgbh_pkg::HEIGHT_W-1:0]   dividend,
    input  logic [DEN_W-1:0]                      divisor,
    output logic [rgbh_pkg::HEIGHT_W-1:0]         quotient,
    output rgbh_pkg::div_status_t                 status
);
    import rgbh_pkg::*;

    localparam int STEP_W = $clog2(HEIGHT_W);

    logic [DEN_W-1:0]    r_reg;
    logic [DEN_W-1:0]    d_reg;
    logic [HEIGHT_W-1:0] n_reg;
    logic [HEIGHT_W-1:0] q_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [DEN_W:0]      trial;
    logic                fits;
    logic [DEN_W-1:0]    r_next;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        trial  = {r_reg, n_reg[HEIGHT_W-1]};
        fits   = (trial >= {1'b0, d_reg});
        r_next = fits ? DEN_W'(trial - {1'b0, d_reg}) : DEN_W'(trial);
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(HEIGHT_W - 1);
        end else if (busy_reg) begin
            if (step_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                step_reg <= step_reg - 1'b1;
            end
        end
    end

    // Datapath; upper dividend bits are below the divisor by construction
    always_ff @(posedge aclk) begin
        if (start) begin
            r_reg <= dividend[DEN_W+HEIGHT_W-1 -: DEN_W];
            n_reg <= dividend[HEIGHT_W-1:0];
            d_reg <= divisor;
            q_reg <= '0;
        end else if (busy_reg) begin
            r_reg <= r_next;
            n_reg <= {n_reg[HEIGHT_W-2:0], 1'b0};
            q_reg <= {q_reg[HEIGHT_W-2:0], fits};
        end
    end

    assign quotient    = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_last_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !start && step_reg == '0) |=> (done_reg && !busy_reg))
        else $error("divider did not finish after last step");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done and busy at once");

endmodule

@@ rtl/core/rgb_histogram_max_normalized.sv @@
// Top level of the RGB histogram with per-channel maximum and scaled readout.
//
//  port group   dir  handshake         contents
//  s_*          in   tvalid/tready     request: pixel, bin read or clear
//  m_*          out  tvalid/tready     bin read result
//  cfg_*        in   write enable      plot_height register
//
// A pixel request does one read-modify-write per channel on the single read
// port and single write port of the bin memory. A bin read runs through
// accept, fetch, multiply, divider start, 12 divider steps and load, and waits
// at load while m_tready stalls the output; s_tready is low meanwhile.
// Reset and a clear request sweep all 3*BINS entries (768 by default), one per
// cycle, with s_tready low. A stalled result holds in the output register.
module rgb_histogram_max_normalized #(
    parameter int BINS       = 256,
    parameter int COUNT_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // fields from bit 0: red[7:0], green[15:8], blue[23:16], channel[25:24],
    // bin[33:26], zero pad[39:34]
    input  logic [rgbh_pkg::S_DATA_W-1:0]     s_tdata,
    // fields from bit 0: mode[1:0]
    input  logic [1:0]                        s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // fields from bit 0: count[23:0], height[35:24], max_count[59:36],
    // zero pad[63:60]
    output logic [rgbh_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [rgbh_pkg::HEIGHT_W-1:0]     cfg_wdata
);
    import rgbh_pkg::*;

    localparam int DEPTH  = CH_COUNT * BINS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = COUNT_BITS + HEIGHT_W;
    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};

    // Component is a real bin
    function automatic logic comp_ok(input logic [COMP_W-1:0] v);
        return ({24'd0, v} < 32'(BINS));
    endfunction

    // Memory address of a channel's bin, zero when out of range
    function automatic logic [ADDR_W-1:0] bin_addr(input logic [1:0] ch,
                                                   input logic [COMP_W-1:0] v);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(ch) * ADDR_W'(BINS) + ADDR_W'(v);
        return comp_ok(v) ? a : '0;
    endfunction

    // Request fields
    logic [COMP_W-1:0] s_red, s_green, s_blue, s_bin;
    logic [1:0]        s_channel, s_mode;
    logic              s_accept;

    assign s_red     = s_tdata[7:0];
    assign s_green   = s_tdata[15:8];
    assign s_blue    = s_tdata[23:16];
    assign s_channel = s_tdata[25:24];
    assign s_bin     = s_tdata[33:26];
    assign s_mode    = s_tuser;
    assign s_accept  = s_tvalid && s_tready;

    hist_state_t state_reg, state_next;

    // Bin memory
    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] mem_rdata_reg;
    logic [ADDR_W-1:0]     mem_raddr;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    // Write-back stage
    logic                  wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0]     wb_addr_reg;
    logic [1:0]            wb_ch_reg, wb_ch_next;
    logic [COUNT_BITS-1:0] wb_new;

    logic [COUNT_BITS-1:0] max_reg [CH_COUNT];
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [HEIGHT_W-1:0]   ph_reg;

    logic [COMP_W-1:0]     pix_g_reg, pix_b_reg;
    logic [1:0]            rd_ch_reg;
    logic [COMP_W-1:0]     rd_bin_reg;
    logic                  rd_ok_reg;

    logic [COUNT_BITS-1:0] cnt_sel, mx_sel;
    logic [COUNT_BITS-1:0] cnt_reg, mx_reg;
    logic [PROD_W-1:0]     prod_reg;

    logic                  div_start;
    logic [HEIGHT_W-1:0]   div_q;
    div_status_t           div_stat;
    logic [HEIGHT_W-1:0]   height;
    logic                  out_load;

    logic [M_DATA_W-1:0]   m_tdata_reg;
    logic                  m_tvalid_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == LAST_ADDR) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_mode)
                        MODE_PIXEL: state_next = ST_PIX_G;
                        MODE_READ:  state_next = ST_RD_ISSUE;
                        MODE_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIX_G:    state_next = ST_PIX_B;
            ST_PIX_B:    state_next = ST_IDLE;
            ST_RD_ISSUE: state_next = ST_RD_DATA;
            ST_RD_DATA:  state_next = ST_RD_START;
            ST_RD_START: state_next = ST_RD_DIV;
            ST_RD_DIV: begin
                if (div_stat.done && (!m_tvalid_reg || m_tready)) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Saturating increment of the word read for write-back
    assign wb_new = (mem_rdata_reg == CNT_MAX) ? mem_rdata_reg : mem_rdata_reg + 1'b1;

    // Strobes and addresses
    always_comb begin
        s_tready      = 1'b0;
        mem_raddr     = '0;
        wb_valid_next = 1'b0;
        wb_ch_next    = CH_RED;
        div_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                mem_raddr     = bin_addr(CH_RED, s_red);
                wb_valid_next = s_tvalid && (s_mode == MODE_PIXEL) && comp_ok(s_red);
                wb_ch_next    = CH_RED;
            end
            ST_PIX_G: begin
                mem_raddr     = bin_addr(CH_GREEN, pix_g_reg);
                wb_valid_next = comp_ok(pix_g_reg);
                wb_ch_next    = CH_GREEN;
            end
            ST_PIX_B: begin
                mem_raddr     = bin_addr(CH_BLUE, pix_b_reg);
                wb_valid_next = comp_ok(pix_b_reg);
                wb_ch_next    = CH_BLUE;
            end
            ST_RD_ISSUE: begin
                mem_raddr = rd_ok_reg ? bin_addr(rd_ch_reg, rd_bin_reg) : '0;
            end
            ST_RD_START: begin
                div_start = 1'b1;
            end
            ST_RD_DIV: begin
                out_load = div_stat.done && (!m_tvalid_reg || m_tready);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase

        // Write port: the sweep owns it during clear
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = wb_valid_reg;
            mem_waddr = wb_addr_reg;
            mem_wdata = wb_new;
        end
    end

    // Memory ports
    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            wb_valid_reg <= 1'b0;
            clr_addr_reg <= '0;
            ph_reg       <= PLOT_HEIGHT_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wb_valid_reg <= wb_valid_next;
            if (s_accept && s_mode == MODE_CLEAR) begin
                clr_addr_reg <= '0;
            end else if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_we) ph_reg <= cfg_wdata;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Channel maxima: drop during clear, raise on write-back
    always_ff @(posedge aclk) begin
        if (!aresetn || state_reg == ST_CLEAR) begin
            for (int i = 0; i < CH_COUNT; i++) max_reg[i] <= '0;
        end else if (wb_valid_reg && wb_new > max_reg[wb_ch_reg]) begin
            max_reg[wb_ch_reg] <= wb_new;
        end
    end

    // Hold request fields and the write-back address
    always_ff @(posedge aclk) begin
        wb_addr_reg <= mem_raddr;
        wb_ch_reg   <= wb_ch_next;
        if (s_accept) begin
            pix_g_reg  <= s_green;
            pix_b_reg  <= s_blue;
            rd_ok_reg  <= (s_channel != CH_NONE) && comp_ok(s_bin);
            rd_ch_reg  <= (s_channel != CH_NONE) ? s_channel : CH_RED;
            rd_bin_reg <= s_bin;
        end
    end

    // Read result: pick count and maximum, then scale
    assign cnt_sel = rd_ok_reg ? mem_rdata_reg : '0;
    assign mx_sel  = rd_ok_reg ? max_reg[rd_ch_reg] : '0;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD_DATA) begin
            cnt_reg  <= cnt_sel;
            mx_reg   <= mx_sel;
            prod_reg <= PROD_W'(cnt_sel) * PROD_W'(ph_reg);
        end
    end

    rgbh_div #(
        .DEN_W (COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (mx_reg),
        .quotient (div_q),
        .status   (div_stat)
    );

    assign height = (mx_reg == '0) ? '0 : div_q;

    // Output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {4'd0, OUT_CNT_W'(mx_reg), height, OUT_CNT_W'(cnt_reg)};
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    a_clear_no_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !wb_valid_reg)
        else $error("write-back pending during clear sweep");

    a_read_after_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_ISSUE) |-> !wb_valid_reg)
        else $error("bin read overlaps a pending write-back");

    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (div_stat.done && !div_stat.busy))
        else $error("result loaded before divider finished");

    a_max_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        wb_valid_reg |=> (max_reg[$past(wb_ch_reg)] >= $past(wb_new)))
        else $error("channel maximum below a written count");

endmodule
